@@ rtl/core/ccp_pkg.sv @@
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types, constants and table functions of the CAT command parser:
// the command name table, reply text segments and sequencer states.
// ----------------------------------------------------------------------------
package ccp_pkg;

   localparam int MSG_MAX_LEN_DEF = 32;
   localparam int BIN_WIDTH       = 32;
   localparam int BCD_DIGITS      = 10;
   localparam int BCD_WIDTH       = 4 * BCD_DIGITS;
   localparam int SEG_CHARS       = 14;
   localparam int SEG_WIDTH       = 8 * SEG_CHARS;

   localparam logic [31:0] FREQ_RESET = 32'd50260000;
   localparam logic [7:0]  MODE_RESET = 8'd2;

   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_HEX_MARK = 8'h23;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_VT_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_UP_A     = 8'h41;
   localparam logic [7:0] CH_UP_F     = 8'h46;
   localparam logic [7:0] CH_UP_X     = 8'h58;
   localparam logic [7:0] CH_LOW_A    = 8'h61;
   localparam logic [7:0] CH_LOW_Z    = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef enum logic {
      CSR_ADD_NEWLINE  = 1'b0,
      CSR_KEY_TRANSMIT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD0, ST_RD1, ST_MATCH, ST_PADDR, ST_PDATA, ST_CONV,
      ST_PRE, ST_DEC, ST_POST, ST_CR, ST_LF, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      C_IF, C_OI, C_RI, C_IS, C_SH, C_SM, C_NA, C_TX, C_FA, C_FB, C_MD,
      C_EX, C_RM, C_ST, C_SV, C_AB, C_BA, C_BS, C_AI, C_ID, C_CL
   } cmd_code_type;

   typedef enum logic [1:0] {K_BOTH, K_STS, K_CMD} kind_type;

   typedef enum logic [2:0] {D_NONE, D_FREQ_A, D_FREQ_B, D_SPLIT, D_TX} dec_sel_type;

   typedef struct packed {
      logic         found;
      logic [1:0]   nlen;
      kind_type     kind;
      cmd_code_type code;
   } entry_type;

   typedef logic [SEG_WIDTH-1:0] seg_text_type;

   typedef struct packed {
      logic [3:0]   len;
      seg_text_type txt;
   } seg_type;

   typedef struct packed {
      logic                 start;
      logic [BIN_WIDTH-1:0] value;
   } conv_req_type;

   function automatic entry_type cmd_lookup(input logic [7:0] c0, input logic [7:0] c1);
      entry_type e;
      e = '{found: 1'b1, nlen: 2'd2, kind: K_BOTH, code: C_IF};
      case ({c0, c1})
         "IF": e.code = C_IF;
         "OI": e.code = C_OI;
         "RI": begin e.nlen = 2'd3; e.kind = K_STS; e.code = C_RI; end
         "IS": begin e.nlen = 2'd3; e.kind = K_STS; e.code = C_IS; end
         "SH": begin e.nlen = 2'd3; e.kind = K_STS; e.code = C_SH; end
         "SM": begin e.nlen = 2'd3; e.kind = K_STS; e.code = C_SM; end
         "NA": begin e.nlen = 2'd3; e.kind = K_STS; e.code = C_NA; end
         "TX": e.code = C_TX;
         "FA": e.code = C_FA;
         "FB": e.code = C_FB;
         "MD": begin e.nlen = 2'd3; e.code = C_MD; end
         "EX": e.code = C_EX;
         "RM": begin e.kind = K_STS; e.code = C_RM; end
         "ST": e.code = C_ST;
         "SV": begin e.kind = K_CMD; e.code = C_SV; end
         "AB": begin e.kind = K_CMD; e.code = C_AB; end
         "BA": begin e.kind = K_CMD; e.code = C_BA; end
         "BS": e.code = C_BS;
         "AI": e.code = C_AI;
         "ID": begin e.kind = K_STS; e.code = C_ID; end
         "CL": begin e.kind = K_STS; e.code = C_CL; end
         default: e.found = 1'b0;
      endcase
      return e;
   endfunction

   function automatic dec_sel_type dec_select(input cmd_code_type code);
      dec_sel_type d;
      case (code)
         C_IF, C_FA: d = D_FREQ_A;
         C_OI, C_FB: d = D_FREQ_B;
         C_RI, C_ST: d = D_SPLIT;
         C_TX:       d = D_TX;
         default:    d = D_NONE;
      endcase
      return d;
   endfunction

   // text before (post = 0) and after (post = 1) the decimal field
   function automatic seg_type seg_info(input cmd_code_type code, input logic post);
      seg_type s;
      s = '{len: 4'd0, txt: '0};
      case (code)
         C_IF: s = post ? seg_type'{4'd14, seg_text_type'("+000000#00000;")}
                        : seg_type'{4'd5, seg_text_type'("IF000")};
         C_OI: s = post ? seg_type'{4'd14, seg_text_type'("+000000#00000;")}
                        : seg_type'{4'd5, seg_text_type'("OI000")};
         C_RI: s = post ? seg_type'{4'd1, seg_text_type'(";")}
                        : seg_type'{4'd3, seg_text_type'("RIC")};
         C_IS: if (!post) s = seg_type'{4'd10, seg_text_type'("IS00+0000;")};
         C_SH: if (!post) s = seg_type'{4'd7, seg_text_type'("SH0120;")};
         C_SM: if (!post) s = seg_type'{4'd7, seg_text_type'("SM0000;")};
         C_NA: if (!post) s = seg_type'{4'd5, seg_text_type'("NA00;")};
         C_TX: s = post ? seg_type'{4'd1, seg_text_type'(";")}
                        : seg_type'{4'd2, seg_text_type'("TX")};
         C_FA: s = post ? seg_type'{4'd1, seg_text_type'(";")}
                        : seg_type'{4'd2, seg_text_type'("FA")};
         C_FB: s = post ? seg_type'{4'd1, seg_text_type'(";")}
                        : seg_type'{4'd2, seg_text_type'("FB")};
         C_MD: if (!post) s = seg_type'{4'd5, seg_text_type'("MD0#;")};
         C_ST: s = post ? seg_type'{4'd1, seg_text_type'(";")}
                        : seg_type'{4'd2, seg_text_type'("ST")};
         C_AI: if (!post) s = seg_type'{4'd4, seg_text_type'("AI0;")};
         C_ID: if (!post) s = seg_type'{4'd7, seg_text_type'("ID0650;")};
         default: s = '{len: 4'd0, txt: '0};
      endcase
      return s;
   endfunction

   function automatic logic [7:0] seg_char(input seg_type s, input logic [3:0] idx);
      logic [3:0] pos;
      pos = s.len - 4'd1 - idx;
      return s.txt[{pos, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      return (d < 4'd10) ? (CH_ZERO + {4'd0, d}) : (CH_UP_A + {4'd0, d} - 8'd10);
   endfunction

endpackage

@@ rtl/core/ccp_bcd_conv.sv @@
// ----------------------------------------------------------------------------
// ccp_bcd_conv
// Iterative binary to BCD converter, one shift-and-add-three step per cycle.
// ----------------------------------------------------------------------------
module ccp_bcd_conv (
   input  logic                           clock,
   input  logic                           reset,
   input  ccp_pkg::conv_req_type          conv_req,
   output logic                           busy,
   output logic [ccp_pkg::BCD_WIDTH-1:0]  digits
);

   localparam int CW = $clog2(ccp_pkg::BIN_WIDTH + 1);

   logic [ccp_pkg::BIN_WIDTH-1:0] bin_ff, bin_in;
   logic [ccp_pkg::BCD_WIDTH-1:0] bcd_ff, bcd_in, adj;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;

   always_comb begin
      for (int i = 0; i < ccp_pkg::BCD_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] > 4'd4) ? bcd_ff[4*i +: 4] + 4'd3
                                                     : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (conv_req.start) begin
         bin_in  = conv_req.value;
         bcd_in  = '0;
         cnt_in  = CW'(ccp_pkg::BIN_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in  = {adj[ccp_pkg::BCD_WIDTH-2:0], bin_ff[ccp_pkg::BIN_WIDTH-1]};
         bin_in  = {bin_ff[ccp_pkg::BIN_WIDTH-2:0], 1'b0};
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign busy   = busy_ff;
   assign digits = bcd_ff;

endmodule

@@ rtl/core/cat_command_parser_core.sv @@
// ----------------------------------------------------------------------------
// cat_command_parser_core
// CAT command parser: buffers received characters up to ';', matches the
// command name, applies set commands and streams status replies.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_rx_byte
//  rsp     | out       | rsp_valid/rsp_ready  | reply character, flags, radio state
//  csr     | in        | csr_we               | csr_index, csr_wdata
//
//  a byte other than ';' gives one beat
//  ';' with a set command: ST_RD0, ST_RD1, ST_MATCH match the name, then
//  ST_PADDR and ST_PDATA per data byte read by the scan (message buffer port)
//  ';' with a status request: after the name match, a reply with a number field
//  runs the 32-step decimal converter; each beat waits while rsp_ready is low
//  reset restores the radio state and empties the message buffer
// ----------------------------------------------------------------------------
module cat_command_parser_core #(
   parameter int MSG_MAX_LEN = ccp_pkg::MSG_MAX_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_has_char,
   output logic [7:0]  rsp_reply_char,
   output logic        rsp_last,
   output logic        rsp_tx_key,
   output logic        rsp_command_applied,
   output logic [31:0] rsp_vfo_a_hz,
   output logic [31:0] rsp_vfo_b_hz,
   output logic [7:0]  rsp_mode_a_out,
   output logic [7:0]  rsp_mode_b_out,
   output logic [7:0]  rsp_split_out,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata
);

   localparam int LW = $clog2(MSG_MAX_LEN + 1);
   localparam int AW = $clog2(MSG_MAX_LEN);

   ccp_pkg::state_type     state_ff, state_in;
   ccp_pkg::cmd_code_type  code_ff, code_in;
   ccp_pkg::entry_type     entry;
   ccp_pkg::seg_type       seg_pre, seg_post, seg_match;
   ccp_pkg::dec_sel_type   dsel;
   ccp_pkg::conv_req_type  conv_req;

   logic [7:0]  mem [MSG_MAX_LEN];
   logic [7:0]  rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic        mem_we;

   logic [LW-1:0] msg_len_ff, msg_len_in;
   logic [LW-1:0] proc_len_ff, proc_len_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [7:0]  c0_ff, c0_in;
   logic [31:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        ph_ff, ph_in;
   logic        applied_ff, applied_in;
   logic [3:0]  pos_ff, pos_in;
   logic [3:0]  dig_ff, dig_in;
   logic [31:0] freq_a_ff, freq_a_in, freq_b_ff, freq_b_in;
   logic [7:0]  mode_a_ff, mode_a_in, mode_b_ff, mode_b_in;
   logic [7:0]  split_ff, split_in, tx_ff, tx_in;
   logic        add_newline_ff, key_transmit_ff;

   logic        rsp_valid_ff, rsp_has_char_ff, rsp_last_ff, rsp_applied_ff;
   logic [7:0]  rsp_char_ff;
   logic        load, load_has_char, load_last;
   logic [7:0]  load_char;

   logic        out_free, accept, is_term, conv_busy;
   logic [7:0]  up_byte, b, pre_char, post_char;
   logic [ccp_pkg::BCD_WIDTH-1:0] digits;
   logic [3:0]  top_dig, hex_nib;
   logic        is_cmd, pre_end, post_end, is_ws, is_dig, is_hex_letter, stop, commit;
   logic [31:0] conv_value;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ccp_pkg::ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign is_term   = req_rx_byte == ccp_pkg::CH_SEMI;
   assign up_byte   = (req_rx_byte >= ccp_pkg::CH_LOW_A && req_rx_byte <= ccp_pkg::CH_LOW_Z)
                      ? req_rx_byte - ccp_pkg::CASE_OFFSET : req_rx_byte;
   assign mem_we    = accept && !is_term && (msg_len_ff < LW'(MSG_MAX_LEN));

   // message buffer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[msg_len_ff[AW-1:0]] <= up_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      case (state_ff)
         ccp_pkg::ST_RD1:   rd_addr = AW'(1);
         ccp_pkg::ST_PADDR: rd_addr = idx_ff[AW-1:0];
         default:           rd_addr = '0;
      endcase
   end

   assign b         = rd_data_ff;
   assign entry     = ccp_pkg::cmd_lookup(c0_ff, rd_data_ff);
   assign is_cmd    = (proc_len_ff > LW'(entry.nlen)) || (entry.kind == ccp_pkg::K_CMD);
   assign seg_pre   = ccp_pkg::seg_info(code_ff, 1'b0);
   assign seg_post  = ccp_pkg::seg_info(code_ff, 1'b1);
   assign seg_match = ccp_pkg::seg_info(entry.code, 1'b0);
   assign dsel      = ccp_pkg::dec_select(entry.code);
   assign pre_end   = pos_ff == seg_pre.len - 4'd1;
   assign post_end  = pos_ff == seg_post.len - 4'd1;
   assign hex_nib   = (code_ff == ccp_pkg::C_OI) ? mode_b_ff[3:0] : mode_a_ff[3:0];

   assign is_ws  = b == ccp_pkg::CH_SPACE || (b >= ccp_pkg::CH_TAB && b <= ccp_pkg::CH_VT_CR);
   assign is_dig = b >= ccp_pkg::CH_ZERO && b <= ccp_pkg::CH_NINE;
   assign is_hex_letter = b >= ccp_pkg::CH_UP_A && b <= ccp_pkg::CH_UP_F;

   always_comb begin
      pre_char = ccp_pkg::seg_char(seg_pre, pos_ff);
      if (pre_char == ccp_pkg::CH_HEX_MARK) pre_char = ccp_pkg::hex_char(hex_nib);
      post_char = ccp_pkg::seg_char(seg_post, pos_ff);
      if (post_char == ccp_pkg::CH_HEX_MARK) post_char = ccp_pkg::hex_char(hex_nib);
   end

   always_comb begin
      case (dsel)
         ccp_pkg::D_FREQ_A: conv_value = freq_a_ff;
         ccp_pkg::D_FREQ_B: conv_value = freq_b_ff;
         ccp_pkg::D_SPLIT:  conv_value = {24'd0, split_ff};
         ccp_pkg::D_TX:     conv_value = {24'd0, tx_ff};
         default:           conv_value = '0;
      endcase
   end

   always_comb begin
      top_dig = 4'd0;
      for (int i = 0; i < ccp_pkg::BCD_DIGITS; i++) begin
         if (digits[4*i +: 4] != 4'd0) top_dig = 4'(i);
      end
      if (code_ff == ccp_pkg::C_IF || code_ff == ccp_pkg::C_OI
          || code_ff == ccp_pkg::C_FA || code_ff == ccp_pkg::C_FB) begin
         top_dig = (digits[4*(ccp_pkg::BCD_DIGITS-1) +: 4] != 4'd0) ? 4'd9 : 4'd8;
      end
   end

   // stop condition of the data scan
   always_comb begin
      stop = 1'b0;
      case (code_ff)
         ccp_pkg::C_FA, ccp_pkg::C_FB:
            stop = !((!ph_ff && (is_ws || b == ccp_pkg::CH_PLUS || b == ccp_pkg::CH_MINUS))
                     || is_dig);
         ccp_pkg::C_MD: stop = !(b == ccp_pkg::CH_UP_X || is_dig || is_hex_letter);
         default:       stop = 1'b1;
      endcase
   end

   assign commit = (state_ff == ccp_pkg::ST_PADDR && idx_ff == proc_len_ff)
                   || (state_ff == ccp_pkg::ST_PDATA && stop);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ccp_pkg::ST_IDLE:
            if (accept && is_term) begin
               state_in = (msg_len_ff < LW'(2)) ? ccp_pkg::ST_DONE : ccp_pkg::ST_RD0;
            end
         ccp_pkg::ST_RD0: state_in = ccp_pkg::ST_RD1;
         ccp_pkg::ST_RD1: state_in = ccp_pkg::ST_MATCH;
         ccp_pkg::ST_MATCH:
            if (!entry.found || proc_len_ff < LW'(entry.nlen)) begin
               state_in = ccp_pkg::ST_DONE;
            end else if (is_cmd) begin
               unique case (entry.code)
                  ccp_pkg::C_FA, ccp_pkg::C_FB, ccp_pkg::C_MD,
                  ccp_pkg::C_ST, ccp_pkg::C_TX: state_in = ccp_pkg::ST_PADDR;
                  default:                      state_in = ccp_pkg::ST_DONE;
               endcase
            end else if (dsel != ccp_pkg::D_NONE) begin
               state_in = ccp_pkg::ST_CONV;
            end else if (seg_match.len != 4'd0) begin
               state_in = ccp_pkg::ST_PRE;
            end else begin
               state_in = ccp_pkg::ST_DONE;
            end
         ccp_pkg::ST_PADDR:
            state_in = commit ? ccp_pkg::ST_DONE : ccp_pkg::ST_PDATA;
         ccp_pkg::ST_PDATA:
            state_in = stop ? ccp_pkg::ST_DONE : ccp_pkg::ST_PADDR;
         ccp_pkg::ST_CONV:
            if (!conv_busy) state_in = ccp_pkg::ST_PRE;
         ccp_pkg::ST_PRE:
            if (out_free && pre_end) begin
               if (ccp_pkg::dec_select(code_ff) != ccp_pkg::D_NONE) state_in = ccp_pkg::ST_DEC;
               else if (add_newline_ff) state_in = ccp_pkg::ST_CR;
               else state_in = ccp_pkg::ST_IDLE;
            end
         ccp_pkg::ST_DEC:
            if (out_free && dig_ff == 4'd0) state_in = ccp_pkg::ST_POST;
         ccp_pkg::ST_POST:
            if (out_free && post_end) begin
               state_in = add_newline_ff ? ccp_pkg::ST_CR : ccp_pkg::ST_IDLE;
            end
         ccp_pkg::ST_CR:   if (out_free) state_in = ccp_pkg::ST_LF;
         ccp_pkg::ST_LF:   if (out_free) state_in = ccp_pkg::ST_IDLE;
         ccp_pkg::ST_DONE: if (out_free) state_in = ccp_pkg::ST_IDLE;
         default:          state_in = ccp_pkg::ST_IDLE;
      endcase
   end

   // datapath and beat loading
   always_comb begin
      msg_len_in  = msg_len_ff;
      proc_len_in = proc_len_ff;
      idx_in      = idx_ff;
      c0_in       = c0_ff;
      code_in     = code_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      ph_in       = ph_ff;
      applied_in  = applied_ff;
      pos_in      = pos_ff;
      dig_in      = dig_ff;
      freq_a_in   = freq_a_ff;
      freq_b_in   = freq_b_ff;
      mode_a_in   = mode_a_ff;
      mode_b_in   = mode_b_ff;
      split_in    = split_ff;
      tx_in       = tx_ff;
      conv_req    = '{start: 1'b0, value: conv_value};
      load          = 1'b0;
      load_has_char = 1'b0;
      load_char     = 8'd0;
      load_last     = 1'b0;
      unique case (state_ff)
         ccp_pkg::ST_IDLE:
            if (accept) begin
               applied_in = 1'b0;
               if (is_term) begin
                  proc_len_in = msg_len_ff;
                  msg_len_in  = '0;
               end else begin
                  if (mem_we) msg_len_in = msg_len_ff + LW'(1);
                  load      = 1'b1;
                  load_last = 1'b1;
               end
            end
         ccp_pkg::ST_RD0: ;
         ccp_pkg::ST_RD1: c0_in = rd_data_ff;
         ccp_pkg::ST_MATCH: begin
            code_in = entry.code;
            idx_in  = LW'(entry.nlen);
            acc_in  = '0;
            neg_in  = 1'b0;
            ph_in   = 1'b0;
            pos_in  = 4'd0;
            if (entry.found && proc_len_ff >= LW'(entry.nlen)) begin
               if (is_cmd) begin
                  unique case (entry.code)
                     ccp_pkg::C_AB: begin
                        freq_b_in = freq_a_ff;
                        mode_b_in = mode_a_ff;
                        applied_in = 1'b1;
                     end
                     ccp_pkg::C_BA: begin
                        freq_a_in = freq_b_ff;
                        mode_a_in = mode_b_ff;
                        applied_in = 1'b1;
                     end
                     ccp_pkg::C_SV: begin
                        freq_a_in = freq_b_ff;
                        mode_a_in = mode_b_ff;
                        freq_b_in = freq_a_ff;
                        mode_b_in = mode_a_ff;
                        applied_in = 1'b1;
                     end
                     ccp_pkg::C_EX, ccp_pkg::C_IF, ccp_pkg::C_IS, ccp_pkg::C_OI,
                     ccp_pkg::C_RM, ccp_pkg::C_SM: applied_in = 1'b1;
                     default: ;
                  endcase
               end else if (dsel != ccp_pkg::D_NONE) begin
                  conv_req.start = 1'b1;
               end
            end
         end
         ccp_pkg::ST_PADDR: ;
         ccp_pkg::ST_PDATA:
            if (!stop) begin
               idx_in = idx_ff + LW'(1);
               if (code_ff == ccp_pkg::C_MD) begin
                  if (is_dig) acc_in = {24'd0, acc_ff[3:0], b[3:0]};
                  else if (is_hex_letter) acc_in = {24'd0, acc_ff[3:0], b[3:0] + 4'd9};
               end else if (is_dig) begin
                  acc_in = {acc_ff[28:0], 3'b000} + {acc_ff[30:0], 1'b0} + {28'd0, b[3:0]};
                  ph_in  = 1'b1;
               end else if (!is_ws) begin
                  neg_in = b == ccp_pkg::CH_MINUS;
                  ph_in  = 1'b1;
               end
            end else if (code_ff == ccp_pkg::C_ST) begin
               split_in = b - ccp_pkg::CH_ZERO;
            end else if (code_ff == ccp_pkg::C_TX) begin
               tx_in = b - ccp_pkg::CH_ZERO;
            end
         ccp_pkg::ST_CONV: dig_in = top_dig;
         ccp_pkg::ST_PRE:
            if (out_free) begin
               load          = 1'b1;
               load_has_char = 1'b1;
               load_char     = pre_char;
               load_last     = pre_end && !add_newline_ff
                               && ccp_pkg::dec_select(code_ff) == ccp_pkg::D_NONE;
               pos_in        = pos_ff + 4'd1;
            end
         ccp_pkg::ST_DEC:
            if (out_free) begin
               load          = 1'b1;
               load_has_char = 1'b1;
               load_char     = ccp_pkg::CH_ZERO + {4'd0, digits[{dig_ff, 2'b00} +: 4]};
               dig_in        = dig_ff - 4'd1;
               pos_in        = 4'd0;
            end
         ccp_pkg::ST_POST:
            if (out_free) begin
               load          = 1'b1;
               load_has_char = 1'b1;
               load_char     = post_char;
               load_last     = post_end && !add_newline_ff;
               pos_in        = pos_ff + 4'd1;
            end
         ccp_pkg::ST_CR:
            if (out_free) begin
               load          = 1'b1;
               load_has_char = 1'b1;
               load_char     = ccp_pkg::CH_CR;
            end
         ccp_pkg::ST_LF:
            if (out_free) begin
               load          = 1'b1;
               load_has_char = 1'b1;
               load_char     = ccp_pkg::CH_LF;
               load_last     = 1'b1;
            end
         ccp_pkg::ST_DONE:
            if (out_free) begin
               load      = 1'b1;
               load_last = 1'b1;
            end
         default: ;
      endcase
      if (commit) begin
         applied_in = 1'b1;
         unique case (code_ff)
            ccp_pkg::C_FA: freq_a_in = neg_ff ? 32'd0 - acc_ff : acc_ff;
            ccp_pkg::C_FB: freq_b_in = neg_ff ? 32'd0 - acc_ff : acc_ff;
            ccp_pkg::C_MD: begin
               mode_a_in = acc_ff[7:0];
               mode_b_in = acc_ff[7:0];
            end
            default: ;
         endcase
      end
   end

   ccp_bcd_conv u_bcd_conv (
      .clock    (clock),
      .reset    (reset),
      .conv_req (conv_req),
      .busy     (conv_busy),
      .digits   (digits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ccp_pkg::ST_IDLE;
         msg_len_ff      <= '0;
         freq_a_ff       <= ccp_pkg::FREQ_RESET;
         freq_b_ff       <= ccp_pkg::FREQ_RESET;
         mode_a_ff       <= ccp_pkg::MODE_RESET;
         mode_b_ff       <= ccp_pkg::MODE_RESET;
         split_ff        <= 8'd0;
         tx_ff           <= 8'd0;
         add_newline_ff  <= 1'b0;
         key_transmit_ff <= 1'b1;
         rsp_valid_ff    <= 1'b0;
         applied_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         msg_len_ff <= msg_len_in;
         freq_a_ff  <= freq_a_in;
         freq_b_ff  <= freq_b_in;
         mode_a_ff  <= mode_a_in;
         mode_b_ff  <= mode_b_in;
         split_ff   <= split_in;
         tx_ff      <= tx_in;
         applied_ff <= applied_in;
         if (csr_we) begin
            unique case (ccp_pkg::csr_index_type'(csr_index))
               ccp_pkg::CSR_ADD_NEWLINE:  add_newline_ff  <= csr_wdata;
               ccp_pkg::CSR_KEY_TRANSMIT: key_transmit_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      proc_len_ff <= proc_len_in;
      idx_ff      <= idx_in;
      c0_ff       <= c0_in;
      code_ff     <= code_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      ph_ff       <= ph_in;
      pos_ff      <= pos_in;
      dig_ff      <= dig_in;
      if (load) begin
         rsp_has_char_ff <= load_has_char;
         rsp_char_ff     <= load_char;
         rsp_last_ff     <= load_last;
         rsp_applied_ff  <= applied_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_has_char        = rsp_has_char_ff;
   assign rsp_reply_char      = rsp_char_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_command_applied = rsp_applied_ff;
   assign rsp_tx_key          = (tx_ff != 8'd0) && key_transmit_ff;
   assign rsp_vfo_a_hz        = freq_a_ff;
   assign rsp_vfo_b_hz        = freq_b_ff;
   assign rsp_mode_a_out      = mode_a_ff;
   assign rsp_mode_b_out      = mode_b_ff;
   assign rsp_split_out       = split_ff;

endmodule
